>>> sv/sphere_set_overlap_test_macros.svh
// Assertion macros shared by the sphere set overlap test RTL.
`ifndef SPHERE_SET_OVERLAP_TEST_MACROS_SVH
`define SPHERE_SET_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTH
// Implication or plain property, sampled on clk_i, off while rst_ni is low.
`define SSOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen at a clock edge.
`define SSOT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SSOT_ASSERT(lbl, prop, msg)
`define SSOT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/ssot_pkg.sv
// Types and constants of the sphere set overlap test.
package ssot_pkg;

  // Input command codes
  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_TEST        = 2'd2;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned SQ_W     = 2 * DIFF_W;      // signed product width
  localparam int unsigned SQU_W    = SQ_W - 1;        // magnitude of a square
  localparam int unsigned D2_W     = SQU_W + 1;       // sum of three squares
  localparam int unsigned RSUM_W   = RADIUS_W + 1;
  localparam int unsigned R2_W     = 2 * RSUM_W;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned MASK_IW  = 5;

  // Command queue between front and engine
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = 2;
  localparam int unsigned QCW    = 3;

  // Classified operation held in the queue
  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_TEST        = 2'd2
  } op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       r;
  } sphere_t;

  typedef struct packed {
    op_e     op;
    sphere_t sph;
  } item_t;

endpackage

>>> sv/sphere_set_overlap_test.sv
// Sphere set overlap test: loads two sphere sets, tests them and returns hit masks.
// Loads (command 0 first set, 1 second set) and tests (command 2) pass through a
// four-entry command queue to the engine; command 3 is accepted and dropped. A test
// walks the pairs through a single distance pipeline at one pair per cycle, except
// where a first-set sphere that already has a hit is skipped: the remaining pairs
// of each first-set sphere are dropped once its hit has come back, and the pipeline
// then drains before the result is handed off. The result waits in an output
// register, so further loads queue and run while it is not yet taken; a following
// test runs its pair walk but holds its result, and the queue behind it, until the
// register is free. Both sets are cleared when a test result issues.
module sphere_set_overlap_test #(
  parameter int unsigned SPHERES_PER_SET = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic [15:0] radius_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] source_hit_mask_o,
  output logic [31:0] target_touch_mask_o
);
  import ssot_pkg::*;

  localparam int unsigned IW = (SPHERES_PER_SET > 1) ? $clog2(SPHERES_PER_SET) : 1;
  localparam int unsigned CW = $clog2(SPHERES_PER_SET + 1);

  sphere_t sphere;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;

  assign sphere.x = center_x_i;
  assign sphere.y = center_y_i;
  assign sphere.z = center_z_i;
  assign sphere.r = radius_i;

  // Front: classify and queue
  ssot_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .command_i (command_i),
    .sphere_i  (sphere),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back: storage, pair walk, result
  ssot_engine #(
    .N  (SPHERES_PER_SET),
    .IW (IW),
    .CW (CW)
  ) u_engine (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_item_i            (q_item),
    .q_pop_o             (q_pop),
    .empty               (empty),
    .pop                 (pop),
    .source_hit_mask_o   (source_hit_mask_o),
    .target_touch_mask_o (target_touch_mask_o)
  );

endmodule

>>> sv/ssot_front.sv
// Front end: accepts items, classifies the command and queues it for the engine.
`include "sphere_set_overlap_test_macros.svh"
module ssot_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      command_i,
  input  ssot_pkg::sphere_t sphere_i,
  output logic            q_valid_o,
  output ssot_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import ssot_pkg::*;

  item_t          fifo_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           accept;
  logic           keep;
  logic           deq;
  item_t          item;

  // Classify the command; the unused code is dropped here
  always_comb begin
    item.sph = sphere_i;
    item.op  = OP_TEST;
    keep     = 1'b0;
    case (command_i)
      CMD_LOAD_FIRST: begin
        item.op = OP_LOAD_FIRST;
        keep    = 1'b1;
      end
      CMD_LOAD_SECOND: begin
        item.op = OP_LOAD_SECOND;
        keep    = 1'b1;
      end
      CMD_TEST: begin
        item.op = OP_TEST;
        keep    = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (cnt_q == QCW'(QDEPTH));
  assign accept    = push && !full;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fifo_q[rd_ptr_q];
  assign deq       = q_pop_i && q_valid_o;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept && keep) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if ((accept && keep) && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!(accept && keep) && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  `SSOT_NEVER(a_q_count_range, cnt_q > QCW'(QDEPTH), "command queue count beyond depth")
  `SSOT_ASSERT(a_q_ptr_gap, wr_ptr_q == rd_ptr_q |-> (cnt_q == '0 || cnt_q == QCW'(QDEPTH)), "queue pointers disagree with count")
  `SSOT_ASSERT(a_q_unused_drop, push && !full && command_i == CMD_UNUSED && !q_pop_i |=> $stable(cnt_q), "unused command entered the queue")

endmodule

>>> sv/ssot_engine.sv
// Back end: sphere set storage, pair walk through the distance pipeline, result register.
`include "sphere_set_overlap_test_macros.svh"
module ssot_engine #(
  parameter int unsigned N  = 32,
  parameter int unsigned IW = 5,
  parameter int unsigned CW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  ssot_pkg::item_t            q_item_i,
  output logic                       q_pop_o,
  output logic                       empty,
  input  logic                       pop,
  output logic [ssot_pkg::MASK_W-1:0] source_hit_mask_o,
  output logic [ssot_pkg::MASK_W-1:0] target_touch_mask_o
);
  import ssot_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  sphere_t mem_a [N];
  sphere_t mem_b [N];
  sphere_t rd_a_q, rd_b_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [MASK_W-1:0] src_q, src_d, tgt_q, tgt_d;
  logic [MASK_W-1:0] src_out_q, tgt_out_q;
  logic out_valid_q, out_valid_d;
  logic out_load;

  logic wr_a, wr_b;
  logic scan_live, i_done, issue;

  // Pipeline valid bits and pair tags
  logic v1_q, v2_q, v3_q, v4_q;
  logic [IW-1:0] ti1_q, ti2_q, ti3_q, ti4_q;
  logic [IW-1:0] tj1_q, tj2_q, tj3_q, tj4_q;
  logic ok3_q, ok4_q;
  logic ok2_q;

  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [RSUM_W-1:0]        rsum_q;
  logic signed [SQ_W-1:0]   sqx_full, sqy_full, sqz_full;
  logic [SQU_W-1:0]         sqx_q, sqy_q, sqz_q;
  logic [R2_W-1:0]          r2_3_q, r2_4_q;
  logic [D2_W-1:0]          d2_q;
  logic                     hit;

  // Queue pop and loads happen only while idle
  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;
  assign wr_a = q_pop_o && (q_item_i.op == OP_LOAD_FIRST) && (cnt_a_q < CW'(N));
  assign wr_b = q_pop_o && (q_item_i.op == OP_LOAD_SECOND) && (cnt_b_q < CW'(N));

  // Pair issue: one (i, j) per cycle; an i already hit is skipped
  assign scan_live = (i_q < cnt_a_q) && (cnt_b_q != '0);
  assign i_done    = src_q[MASK_IW'(i_q[IW-1:0])];
  assign issue     = (st_q == ST_SCAN) && scan_live && !i_done;

  // First hit for a first-set sphere wins; later in-flight pairs are ignored
  assign hit = v4_q && ok4_q && (d2_q < D2_W'(r2_4_q)) && !src_q[MASK_IW'(ti4_q)];

  assign out_load = (st_q == ST_EMIT) && (!out_valid_q || pop);

  // Sequencer
  always_comb begin
    st_d    = st_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    i_d     = i_q;
    j_d     = j_q;
    src_d   = src_q;
    tgt_d   = tgt_q;
    if (wr_a) begin
      cnt_a_d = cnt_a_q + 1'b1;
    end
    if (wr_b) begin
      cnt_b_d = cnt_b_q + 1'b1;
    end
    if (hit) begin
      src_d[MASK_IW'(ti4_q)] = 1'b1;
      tgt_d[MASK_IW'(tj4_q)] = 1'b1;
    end
    case (st_q)
      ST_IDLE: begin
        if (q_pop_o && q_item_i.op == OP_TEST) begin
          i_d   = '0;
          j_d   = '0;
          src_d = '0;
          tgt_d = '0;
          st_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_live) begin
          st_d = ST_DRAIN;
        end else if (i_done || (j_q + CW'(1)) == cnt_b_q) begin
          i_d = i_q + 1'b1;
          j_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!(v1_q || v2_q || v3_q || v4_q)) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cnt_a_d = '0;
          cnt_b_d = '0;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign empty               = !out_valid_q;
  assign source_hit_mask_o   = src_out_q;
  assign target_touch_mask_o = tgt_out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
    end
  end

  // Mask accumulators and result payload
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    tgt_q <= tgt_d;
    if (out_load) begin
      src_out_q <= src_q;
      tgt_out_q <= tgt_q;
    end
  end

  // Sphere memories: one write port for loads, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[IW-1:0]] <= q_item_i.sph;
    end
    if (wr_b) begin
      mem_b[cnt_b_q[IW-1:0]] <= q_item_i.sph;
    end
    rd_a_q <= mem_a[i_q[IW-1:0]];
    rd_b_q <= mem_b[j_q[IW-1:0]];
  end

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign sqz_full = dz_q * dz_q;

  // Distance pipeline: differences, squares, sum, then compare
  always_ff @(posedge clk_i) begin
    ti1_q <= i_q[IW-1:0];
    tj1_q <= j_q[IW-1:0];
    // stage 2: center differences and radius sum
    dx_q   <= {rd_a_q.x[COORD_W-1], rd_a_q.x} - {rd_b_q.x[COORD_W-1], rd_b_q.x};
    dy_q   <= {rd_a_q.y[COORD_W-1], rd_a_q.y} - {rd_b_q.y[COORD_W-1], rd_b_q.y};
    dz_q   <= {rd_a_q.z[COORD_W-1], rd_a_q.z} - {rd_b_q.z[COORD_W-1], rd_b_q.z};
    rsum_q <= RSUM_W'(rd_a_q.r) + RSUM_W'(rd_b_q.r);
    ok2_q  <= (rd_a_q.r != '0) && (rd_b_q.r != '0);
    ti2_q  <= ti1_q;
    tj2_q  <= tj1_q;
    // stage 3: squares
    sqx_q  <= sqx_full[SQU_W-1:0];
    sqy_q  <= sqy_full[SQU_W-1:0];
    sqz_q  <= sqz_full[SQU_W-1:0];
    r2_3_q <= rsum_q * rsum_q;
    ok3_q  <= ok2_q;
    ti3_q  <= ti2_q;
    tj3_q  <= tj2_q;
    // stage 4: squared distance
    d2_q   <= D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
    r2_4_q <= r2_3_q;
    ok4_q  <= ok3_q;
    ti4_q  <= ti3_q;
    tj4_q  <= tj3_q;
  end

  `SSOT_NEVER(a_cnt_a_range, cnt_a_q > CW'(N), "first set count beyond capacity")
  `SSOT_NEVER(a_cnt_b_range, cnt_b_q > CW'(N), "second set count beyond capacity")
  `SSOT_ASSERT(a_no_pop_busy, st_q != ST_IDLE |-> !q_pop_o, "queue popped while a test runs")
  `SSOT_ASSERT(a_emit_drained, st_q == ST_EMIT |-> !(v1_q || v2_q || v3_q || v4_q), "result taken with pairs in flight")
  `SSOT_ASSERT(a_emit_clears, out_load |=> (cnt_a_q == '0 && cnt_b_q == '0), "sets not cleared after a test")

endmodule
